[rtl/sfd_pkg.sv]
package sfd_pkg;

  // framing symbols on the wire
  localparam logic [7:0] SYM_START = 8'hE1;
  localparam logic [7:0] SYM_END   = 8'hE2;
  localparam logic [7:0] SYM_ESC   = 8'hE3;
  localparam logic [7:0] ESC_START = 8'hE4;
  localparam logic [7:0] ESC_END   = 8'hE5;
  localparam logic [7:0] ESC_ESC   = 8'hE6;

  // trailer length: two address bytes and the checksum
  localparam logic [7:0] TAIL_LEN = 8'd3;

  // end-of-frame status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_SHORT = 3'd4;

  // result kinds
  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_STATUS  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_LIMIT = 2'd0;
  localparam logic [1:0] CFG_FIRST_ADDR  = 2'd1;
  localparam logic [1:0] CFG_SECOND_ADDR = 2'd2;

  // token kinds passed from the deframer to the checker
  typedef enum logic [1:0] {
    TOK_START,
    TOK_DATA,
    TOK_END
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;       // decoded byte
    logic [7:0] wsum;       // sum of the element's wire bytes
    logic       emit;       // oldest tail byte leaves as payload
    logic       over;       // frame limit reached on this byte
    logic       too_short;  // end seen with fewer than three bytes
  } sfd_tok_t;

endpackage

[rtl/sfd_front.sv]
module sfd_front import sfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic [7:0] frame_limit_i,
  input  logic       full_i,
  output logic       push_o,
  output sfd_tok_t   tok_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FRAME = 2'd1;
  localparam logic [1:0] PH_ESC   = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] count_inc;
  logic       accept;
  logic       take;
  logic       push;
  logic [7:0] dec_byte;
  logic [7:0] dec_wsum;
  sfd_tok_t   tok;

  assign ready_o   = !full_i;
  assign accept    = valid_i && !full_i;
  assign count_inc = count_q + 8'd1;

  // escape decoding and token classification
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    take     = 1'b0;
    push     = 1'b0;
    dec_byte = byte_i;
    dec_wsum = byte_i;
    tok      = '{kind: TOK_START, data: byte_i, wsum: byte_i,
                 emit: 1'b0, over: 1'b0, too_short: 1'b0};
    case (phase_q)
      PH_FRAME: begin
        if (byte_i == SYM_START) begin
          count_d  = '0;
          push     = 1'b1;
          tok.kind = TOK_START;
        end else if (byte_i == SYM_END) begin
          phase_d       = PH_IDLE;
          push          = 1'b1;
          tok.kind      = TOK_END;
          tok.too_short = count_q < TAIL_LEN;
        end else if (byte_i == SYM_ESC) begin
          phase_d = PH_ESC;
        end else begin
          take = 1'b1;
        end
      end
      PH_ESC: begin
        dec_wsum = SYM_ESC + byte_i;
        if (byte_i == ESC_START) begin
          dec_byte = SYM_START;
          take     = 1'b1;
        end else if (byte_i == ESC_END) begin
          dec_byte = SYM_END;
          take     = 1'b1;
        end else if (byte_i == ESC_ESC) begin
          dec_byte = SYM_ESC;
          take     = 1'b1;
        end else begin
          // bad escape drops the frame
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (byte_i == SYM_START) begin
          phase_d  = PH_FRAME;
          count_d  = '0;
          push     = 1'b1;
          tok.kind = TOK_START;
        end
      end
    endcase

    // one decoded byte joins the frame
    if (take) begin
      push     = 1'b1;
      count_d  = count_inc;
      tok.kind = TOK_DATA;
      tok.data = dec_byte;
      tok.wsum = dec_wsum;
      tok.emit = count_q >= TAIL_LEN;
      tok.over = count_inc >= frame_limit_i;
      phase_d  = tok.over ? PH_IDLE : PH_FRAME;
    end
  end

  assign push_o = accept && push;
  assign tok_o  = tok;

  // phase and decoded count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

[rtl/sfd_queue.sv]
module sfd_queue import sfd_pkg::*; #(
  parameter int unsigned DEPTH = 2  // 2 to 32 entries
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sfd_tok_t push_tok_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output sfd_tok_t tok_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sfd_tok_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign tok_o   = mem_q[rd_ptr_q];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // token storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("token pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("token popped from empty queue");

endmodule

[rtl/sfd_back.sv]
module sfd_back import sfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tok_valid_i,
  input  sfd_tok_t   tok_i,
  output logic       pop_o,
  input  logic [7:0] first_address_i,
  input  logic [7:0] second_address_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [2:0] frame_status_o
);

  logic [7:0] wire_sum_q, wire_sum_d;
  logic [7:0] last_sum_q, last_sum_d;
  logic [7:0] tail_q [3];
  logic       out_valid_q, out_valid_d;
  logic       kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic [2:0] status_q, status_d;
  logic       has_res;
  logic       pop;

  assign pop   = tok_valid_i && (!out_valid_q || res_ready_i);
  assign pop_o = pop;

  // sums and result for the token at the queue head
  always_comb begin
    wire_sum_d = wire_sum_q;
    last_sum_d = last_sum_q;
    has_res    = 1'b0;
    kind_d     = RES_PAYLOAD;
    byte_d     = '0;
    status_d   = ST_OK;
    case (tok_i.kind)
      TOK_START: begin
        wire_sum_d = '0;
        last_sum_d = '0;
      end
      TOK_DATA: begin
        wire_sum_d = wire_sum_q + tok_i.wsum;
        last_sum_d = tok_i.wsum;
        if (tok_i.over) begin
          has_res  = 1'b1;
          kind_d   = RES_STATUS;
          status_d = ST_OVER;
        end else if (tok_i.emit) begin
          has_res = 1'b1;
          byte_d  = tail_q[0];
        end
      end
      TOK_END: begin
        has_res = 1'b1;
        kind_d  = RES_STATUS;
        if (tok_i.too_short) begin
          status_d = ST_SHORT;
        end else if (8'(wire_sum_q - last_sum_q) != tail_q[2]) begin
          status_d = ST_SUM;
        end else if (tail_q[0] != first_address_i
                     || tail_q[1] != second_address_i) begin
          status_d = ST_ADDR;
        end else begin
          status_d = ST_OK;
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = has_res;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      wire_sum_q  <= '0;
      last_sum_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        wire_sum_q <= wire_sum_d;
        last_sum_q <= last_sum_d;
      end
    end
  end

  // trailer delay and result word
  always_ff @(posedge clk_i) begin
    if (pop && tok_i.kind == TOK_DATA) begin
      tail_q[0] <= tail_q[1];
      tail_q[1] <= tail_q[2];
      tail_q[2] <= tok_i.data;
    end
    if (pop && has_res) begin
      kind_q   <= kind_d;
      byte_q   <= byte_d;
      status_q <= status_d;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign payload_byte_o = byte_q;
  assign frame_status_o = status_q;

  a_end_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && tok_i.kind == TOK_END) |=> (res_valid_o && result_kind_o == RES_STATUS))
    else $error("end token did not produce a status word");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && result_kind_o == RES_STATUS) |-> payload_byte_o == 8'd0)
    else $error("status word carries payload bits");

endmodule

[rtl/stuffed_frame_decoder.sv]
// path: the token for a received byte is registered in the token queue, then its result word in the output register
// throughput: one received byte per cycle, sustained while results are taken each cycle
// the token queue between deframer and checker, QUEUE_DEPTH deep, absorbs output stalls
// reset: asynchronous, active low; idle, counts and sums zero, queue and output empty
// reset registers: frame_limit 127, first_address 1, second_address 2
module stuffed_frame_decoder import sfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [2:0] frame_status_o
);

  logic [7:0] frame_limit_q;
  logic [7:0] first_address_q;
  logic [7:0] second_address_q;
  logic       push;
  logic       full;
  logic       pop;
  logic       tok_valid;
  sfd_tok_t   push_tok;
  sfd_tok_t   head_tok;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q    <= 8'd127;
      first_address_q  <= 8'd1;
      second_address_q <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_LIMIT: frame_limit_q    <= cfg_data_i;
        CFG_FIRST_ADDR:  first_address_q  <= cfg_data_i;
        CFG_SECOND_ADDR: second_address_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // deframer
  sfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (rx_valid_i),
    .ready_o       (rx_ready_o),
    .byte_i        (rx_byte_i),
    .frame_limit_i (frame_limit_q),
    .full_i        (full),
    .push_o        (push),
    .tok_o         (push_tok)
  );

  // token queue
  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (tok_valid),
    .tok_o      (head_tok)
  );

  // checksum and address checker
  sfd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tok_valid_i      (tok_valid),
    .tok_i            (head_tok),
    .pop_o            (pop),
    .first_address_i  (first_address_q),
    .second_address_i (second_address_q),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .result_kind_o    (result_kind_o),
    .payload_byte_o   (payload_byte_o),
    .frame_status_o   (frame_status_o)
  );

endmodule
